/* src/jpps_pkg.sv */
// ----------------------------------------------------------------------------
// jpps_pkg
// Shared types and constants for the JSON pretty-print token stream.
// ----------------------------------------------------------------------------
package jpps_pkg;

	localparam int MAX_DEPTH = 31;
	localparam int LEVEL_W   = 6;
	localparam int TOK_MAX   = 4;

	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(MAX_DEPTH);
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -LEVEL_W'(MAX_DEPTH);

	localparam logic [3:0] INDENT_RESET = 4'd4;

	// Characters that steer the formatting.
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_NEWLINE = 1'b1;

	localparam logic [2:0] CLS_PLAIN  = 3'd0;
	localparam logic [2:0] CLS_SQUARE = 3'd1;
	localparam logic [2:0] CLS_CURLY  = 3'd2;
	localparam logic [2:0] CLS_QUOTE  = 3'd3;
	localparam logic [2:0] CLS_COMMA  = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       doc_end;
	} text_item_t;

	typedef struct packed {
		logic       token_kind;
		logic [7:0] out_byte;
		logic [2:0] color_class;
		logic [8:0] indent_spaces;
		logic       run_last;
	} token_item_t;

	// One buffered token; the indentation is resolved when it is sent.
	typedef struct packed {
		logic       kind;
		logic [7:0] chr;
		logic [2:0] cls;
		logic [4:0] level;
	} tok_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic                      in_str;
		logic [7:0]                prev;
		logic                      seen;
		logic                      ignored;
		logic                      owed;
	} parse_state_t;

	typedef struct packed {
		tok_t [TOK_MAX-1:0] toks;
		logic [2:0]         count;
		parse_state_t       nxt;
	} gen_result_t;

endpackage

/* src/jpps_tokgen.sv */
// ----------------------------------------------------------------------------
// jpps_tokgen
// Turns one input byte and the parser state into up to four tokens and the
// next parser state.
// ----------------------------------------------------------------------------
module jpps_tokgen
	import jpps_pkg::*;
(
	input  parse_state_t cur,
	input  text_item_t   item,
	output gen_result_t  res
);

	function automatic logic [4:0] pos_level(input logic signed [LEVEL_W-1:0] l);
		return l[LEVEL_W-1] ? 5'd0 : l[4:0];
	endfunction

	function automatic logic signed [LEVEL_W-1:0] lvl_up(input logic signed [LEVEL_W-1:0] l);
		return (l < LEVEL_MAX) ? l + LEVEL_W'(1) : l;
	endfunction

	function automatic logic signed [LEVEL_W-1:0] lvl_dn(input logic signed [LEVEL_W-1:0] l);
		return (l > LEVEL_MIN) ? l - LEVEL_W'(1) : l;
	endfunction

	function automatic tok_t mk_char(input logic [7:0] c, input logic [2:0] cls);
		tok_t t;
		t.kind  = KIND_CHAR;
		t.chr   = c;
		t.cls   = cls;
		t.level = 5'd0;
		return t;
	endfunction

	function automatic tok_t mk_nl(input logic [2:0] cls, input logic signed [LEVEL_W-1:0] l);
		tok_t t;
		t.kind  = KIND_NEWLINE;
		t.chr   = 8'd0;
		t.cls   = cls;
		t.level = pos_level(l);
		return t;
	endfunction

	logic [7:0]         c;
	logic               is_open;
	logic               is_close;
	logic [2:0]         br_cls;
	logic [2:0]         owed_cls;
	parse_state_t       s;
	tok_t [TOK_MAX-1:0] t;
	logic [2:0]         n;

	assign c        = item.text_byte;
	assign is_open  = (c == CH_LBRACK) || (c == CH_LBRACE);
	assign is_close = (c == CH_RBRACK) || (c == CH_RBRACE);
	assign br_cls   = ((c == CH_LBRACK) || (c == CH_RBRACK)) ? CLS_SQUARE : CLS_CURLY;
	assign owed_cls = (cur.prev == CH_RBRACK) ? CLS_SQUARE : CLS_CURLY;

	always_comb begin
		s = cur;
		t = '0;
		n = 3'd0;
		if (!cur.seen) begin
			s.seen = 1'b1;
			s.prev = c;
			if (is_open) begin
				s.level = lvl_up(cur.level);
				t[n[1:0]] = mk_char(c, br_cls);   n = n + 3'd1;
				t[n[1:0]] = mk_nl(br_cls, s.level); n = n + 3'd1;
			end else if (is_close) begin
				s.level = lvl_dn(cur.level);
				t[n[1:0]] = mk_char(c, br_cls);   n = n + 3'd1;
				s.owed = 1'b1;
			end else begin
				s.ignored = 1'b1;
			end
		end else if (!cur.ignored) begin
			// A bracket's newline held from the previous byte; a comma swallows it.
			if (cur.owed) begin
				s.owed = 1'b0;
				if (c != CH_COMMA) begin
					t[n[1:0]] = mk_nl(owed_cls, cur.level); n = n + 3'd1;
				end
			end
			if (is_open) begin
				if (cur.prev == CH_COLON) begin
					t[n[1:0]] = mk_nl(br_cls, cur.level); n = n + 3'd1;
					s.level = lvl_up(cur.level);
				end else begin
					s.level = lvl_up(cur.level);
					t[n[1:0]] = mk_nl(br_cls, s.level); n = n + 3'd1;
				end
				t[n[1:0]] = mk_char(c, br_cls);   n = n + 3'd1;
				t[n[1:0]] = mk_nl(br_cls, s.level); n = n + 3'd1;
			end else if (is_close) begin
				s.level = lvl_dn(cur.level);
				t[n[1:0]] = mk_nl(br_cls, s.level); n = n + 3'd1;
				t[n[1:0]] = mk_char(c, br_cls);   n = n + 3'd1;
				s.owed = 1'b1;
			end else if (c == CH_QUOTE) begin
				s.in_str = !cur.in_str;
				t[n[1:0]] = mk_char(c, CLS_QUOTE); n = n + 3'd1;
			end else if ((c == CH_COMMA) && !cur.in_str) begin
				t[n[1:0]] = mk_char(c, CLS_COMMA);   n = n + 3'd1;
				t[n[1:0]] = mk_nl(CLS_COMMA, cur.level); n = n + 3'd1;
			end else begin
				t[n[1:0]] = mk_char(c, CLS_PLAIN); n = n + 3'd1;
			end
			s.prev = c;
		end
		// The last byte of a document pays its own owed newline at once.
		if (item.doc_end && !s.ignored && s.owed) begin
			s.owed = 1'b0;
			t[n[1:0]] = mk_nl(br_cls, s.level); n = n + 3'd1;
		end
		if (item.doc_end) begin
			s = '0;
		end
	end

	assign res.toks  = t;
	assign res.count = n;
	assign res.nxt   = s;

endmodule

/* src/json_pretty_print_stream_core.sv */
// ----------------------------------------------------------------------------
// json_pretty_print_stream_core
// Compact JSON in, one byte per word; colored characters and newline marks
// with indentation counts out, one token per word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  text    | in        | text_valid/stall   | text_item_t  (byte, doc_end)
//  tok     | out       | tok_valid/stall    | token_item_t (one token)
//  cfg     | in        | cfg_valid/ready    | 4-bit indent width
//
// A byte is parsed in the cycle it is accepted; its zero to four tokens go into
// a token buffer and leave through the output register at one token per cycle
// while the output is not stalled; the next byte is taken as the last token
// moves out, or while the buffer is empty if the last byte gave none.
// Reset clears the parser state and sets the indent width to 4.
// Downstream stalls hold the output register and, while tokens of the last byte
// remain in the buffer, stall the text channel.
module json_pretty_print_stream_core
	import jpps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  text_item_t  text_word,
	output logic        tok_valid,
	input  logic        tok_stall,
	output token_item_t tok_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	parse_state_t       st_q;
	logic [3:0]         iw_q;
	gen_result_t        gen;
	tok_t [TOK_MAX-1:0] tok_s1;
	logic [2:0]         rem_s1;
	logic [1:0]         idx_s1;
	logic               tok_valid_q;
	token_item_t        tok_q;
	logic               out_load;
	logic               move;
	logic               take;
	tok_t               head;

	jpps_tokgen u_tokgen (
		.cur  (st_q),
		.item (text_word),
		.res  (gen)
	);

	assign cfg_ready  = 1'b1;
	assign out_load   = !tok_valid_q || !tok_stall;
	assign move       = out_load && (rem_s1 != 3'd0);
	assign text_stall = !((rem_s1 == 3'd0) || ((rem_s1 == 3'd1) && move));
	assign take       = text_valid && !text_stall;
	assign head       = tok_s1[idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			iw_q <= INDENT_RESET;
		end else begin
			if (take) begin
				st_q <= gen.nxt;
			end
			if (cfg_valid) begin
				iw_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s1 <= 3'd0;
			idx_s1 <= 2'd0;
		end else if (take) begin
			rem_s1 <= gen.count;
			idx_s1 <= 2'd0;
		end else if (move) begin
			rem_s1 <= rem_s1 - 3'd1;
			idx_s1 <= idx_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_s1 <= gen.toks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (out_load) begin
			tok_valid_q <= (rem_s1 != 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			tok_q.token_kind    <= head.kind;
			tok_q.out_byte      <= head.chr;
			tok_q.color_class   <= head.cls;
			tok_q.indent_spaces <= 9'({4'd0, head.level} * {5'd0, iw_q});
			tok_q.run_last      <= (rem_s1 == 3'd1);
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok_word  = tok_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_s1 <= 3'(TOK_MAX))
		else $error("token buffer count out of range");

	a_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ((rem_s1 == 3'd0) || ((rem_s1 == 3'd1) && move)))
		else $error("byte taken while tokens of the previous byte remain");

	a_nl_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (tok_word.token_kind == KIND_NEWLINE)) |-> (tok_word.out_byte == 8'd0))
		else $error("newline mark carries a character");

	a_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (tok_word.token_kind == KIND_CHAR)) |-> (tok_word.indent_spaces == 9'd0))
		else $error("character token carries indentation");

	a_doc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && text_word.doc_end) |=> (!st_q.seen && !st_q.owed && (st_q.level == '0)))
		else $error("parser state not cleared after end of document");

endmodule
